/* rtl/core/jts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON token scanner package
// Shared types, token and error codes, character constants and the literal
// spelling tables used by the scanner, the result queue and the checker.
// ----------------------------------------------------------------------------
package jts_pkg;

  // Width of the byte offset counter. Offsets wrap at this width.
  localparam int PosBits = 32;
  typedef logic [PosBits-1:0] pos_t;

  // Result queue depth; a byte can leave up to three results behind.
  localparam int QueueDepth   = 4;
  localparam int QueuePtrBits = $clog2(QueueDepth);
  localparam int MaxResults   = 3;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_LITERAL = 3'd1,
    MODE_STRING  = 3'd2,
    MODE_INT     = 3'd3,
    MODE_DOT     = 3'd4,
    MODE_FRAC    = 3'd5
  } mode_t;

  localparam logic [3:0] KIND_LBRACE   = 4'd0;
  localparam logic [3:0] KIND_RBRACE   = 4'd1;
  localparam logic [3:0] KIND_LBRACKET = 4'd2;
  localparam logic [3:0] KIND_RBRACKET = 4'd3;
  localparam logic [3:0] KIND_COMMA    = 4'd4;
  localparam logic [3:0] KIND_COLON    = 4'd5;
  localparam logic [3:0] KIND_NULL     = 4'd6;
  localparam logic [3:0] KIND_STRING   = 4'd9;
  localparam logic [3:0] KIND_NUMBER   = 4'd10;
  localparam logic [3:0] KIND_END      = 4'd11;
  localparam logic [3:0] KIND_ERROR    = 4'd12;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
  localparam logic [1:0] ERR_LITERAL    = 2'd2;
  localparam logic [1:0] ERR_STRING     = 2'd3;

  localparam logic [1:0] LIT_NULL  = 2'd0;
  localparam logic [1:0] LIT_TRUE  = 2'd1;
  localparam logic [1:0] LIT_FALSE = 2'd2;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_F  = 8'h66;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] start;
    logic [31:0] length;
    logic [1:0]  err;
    logic        last;
  } result_t;

  // Everything one scanned byte hands to the result queue.
  typedef struct packed {
    logic [1:0]                 count;
    result_t [MaxResults-1:0]   items;
  } scan_out_t;

  function automatic logic [31:0] to_out32(input pos_t p);
    logic [63:0] wide;
    wide = 64'(p);
    return wide[31:0];
  endfunction

  // Letters that follow the first one: "ull", "rue", "alse".
  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [1:0] idx);
    logic [7:0] ch;
    case ({kind, idx})
      {LIT_TRUE, 2'd0}:  ch = 8'h72;
      {LIT_TRUE, 2'd1}:  ch = 8'h75;
      {LIT_TRUE, 2'd2}:  ch = 8'h65;
      {LIT_FALSE, 2'd0}: ch = 8'h61;
      {LIT_FALSE, 2'd1}: ch = 8'h6C;
      {LIT_FALSE, 2'd2}: ch = 8'h73;
      {LIT_FALSE, 2'd3}: ch = 8'h65;
      {LIT_NULL, 2'd0}:  ch = 8'h75;
      {LIT_NULL, 2'd1}:  ch = 8'h6C;
      {LIT_NULL, 2'd2}:  ch = 8'h6C;
      default:           ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] kind);
    return (kind == LIT_FALSE) ? 3'd4 : 3'd3;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/json_token_scanner.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON token scanner
// Streaming lexer: one source byte per transaction in, one token per
// transaction out.
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+--------------------------------------
//   byte    | byte_valid / byte_ready    | text_byte, final_byte
//   token   | token_valid / token_ready  | token_kind, token_start, token_length,
//           |                            | error_code, last_of_run
//
// A byte is registered on acceptance and scanned when there is room; its first
// token can be taken the cycle after that. One byte per cycle is sustained
// while the output drains one token per cycle; the four-entry result queue
// sets the limit, since a byte is scanned only when three entries are free.
// Reset clears the lexer state and the queue; there is no clearing pass.
// ----------------------------------------------------------------------------
module json_token_scanner (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_ready,
  input  wire logic [7:0]  text_byte,
  input  wire logic        final_byte,
  output logic             token_valid,
  input  wire logic        token_ready,
  output logic [3:0]       token_kind,
  output logic [31:0]      token_start,
  output logic [31:0]      token_length,
  output logic [1:0]       error_code,
  output logic             last_of_run
);

  logic       held;
  logic [7:0] held_byte;
  logic       held_final;
  logic       room;
  logic       step;

  jts_pkg::scan_out_t scan_out;
  jts_pkg::result_t   head;

  assign step       = held && room;
  assign byte_ready = !held || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (byte_ready) begin
      held <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      held_byte  <= text_byte;
      held_final <= final_byte;
    end
  end

  jts_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .text_byte  (held_byte),
    .final_byte (held_final),
    .scan_out   (scan_out)
  );

  jts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .push_data  (scan_out),
    .room       (room),
    .head_valid (token_valid),
    .pop        (token_ready),
    .head       (head)
  );

  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign error_code   = head.err;
  assign last_of_run  = head.last;

endmodule
`default_nettype wire

/* rtl/core/jts_scan.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON token scanner: byte step
// Holds the lexer state and turns one registered byte into up to three
// results combinationally.
// ----------------------------------------------------------------------------
module jts_scan (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic [7:0]         text_byte,
  input  wire logic               final_byte,
  output jts_pkg::scan_out_t      scan_out
);

  jts_pkg::mode_t mode, mode_next;
  logic [1:0]     lit_kind, lit_kind_next;
  logic [1:0]     lit_prog, lit_prog_next;
  jts_pkg::pos_t  pos, pos_next;
  jts_pkg::pos_t  tok_begin, tok_begin_next;
  logic           halted, halted_next;

  // Decode of the byte as if the scanner sat between tokens.
  jts_pkg::mode_t   idle_mode;
  logic             idle_set_begin;
  jts_pkg::pos_t    idle_begin;
  logic [1:0]       idle_kind;
  logic             idle_halt;
  logic             idle_emit;
  jts_pkg::result_t idle_item;

  logic is_digit;
  logic [2:0] prog_inc;
  logic [2:0] cur_len;
  jts_pkg::pos_t pos_inc;
  logic [1:0] n;
  jts_pkg::result_t [jts_pkg::MaxResults-1:0] items;
  logic do_idle;

  function automatic jts_pkg::result_t mk(input logic [3:0] kind, input jts_pkg::pos_t start,
                                          input jts_pkg::pos_t len, input logic [1:0] err);
    jts_pkg::result_t r;
    r.kind   = kind;
    r.start  = jts_pkg::to_out32(start);
    r.length = jts_pkg::to_out32(len);
    r.err    = err;
    r.last   = 1'b0;
    return r;
  endfunction

  assign is_digit = (text_byte >= jts_pkg::CH_ZERO) && (text_byte <= jts_pkg::CH_NINE);
  assign pos_inc  = pos + jts_pkg::PosBits'(1);
  assign cur_len  = jts_pkg::lit_len(lit_kind);
  assign prog_inc = {1'b0, lit_prog} + 3'd1;

  always_comb begin
    idle_mode      = jts_pkg::MODE_IDLE;
    idle_set_begin = 1'b0;
    idle_begin     = pos;
    idle_kind      = jts_pkg::LIT_NULL;
    idle_halt      = 1'b0;
    idle_emit      = 1'b0;
    idle_item      = mk(jts_pkg::KIND_LBRACE, pos, jts_pkg::PosBits'(1), jts_pkg::ERR_NONE);
    case (text_byte)
      jts_pkg::CH_SPACE, jts_pkg::CH_TAB, jts_pkg::CH_CR, jts_pkg::CH_LF: begin
      end
      jts_pkg::CH_LBRACE: idle_emit = 1'b1;
      jts_pkg::CH_RBRACE: begin
        idle_emit      = 1'b1;
        idle_item.kind = jts_pkg::KIND_RBRACE;
      end
      jts_pkg::CH_LBRACK: begin
        idle_emit      = 1'b1;
        idle_item.kind = jts_pkg::KIND_LBRACKET;
      end
      jts_pkg::CH_RBRACK: begin
        idle_emit      = 1'b1;
        idle_item.kind = jts_pkg::KIND_RBRACKET;
      end
      jts_pkg::CH_COMMA: begin
        idle_emit      = 1'b1;
        idle_item.kind = jts_pkg::KIND_COMMA;
      end
      jts_pkg::CH_COLON: begin
        idle_emit      = 1'b1;
        idle_item.kind = jts_pkg::KIND_COLON;
      end
      jts_pkg::CH_LOW_N, jts_pkg::CH_LOW_T, jts_pkg::CH_LOW_F: begin
        idle_mode      = jts_pkg::MODE_LITERAL;
        idle_set_begin = 1'b1;
        idle_kind      = (text_byte == jts_pkg::CH_LOW_N) ? jts_pkg::LIT_NULL :
                         (text_byte == jts_pkg::CH_LOW_T) ? jts_pkg::LIT_TRUE :
                                                            jts_pkg::LIT_FALSE;
      end
      jts_pkg::CH_QUOTE: begin
        // A string's offset points just past the opening quote.
        idle_mode      = jts_pkg::MODE_STRING;
        idle_set_begin = 1'b1;
        idle_begin     = pos_inc;
      end
      default: begin
        if (text_byte == jts_pkg::CH_MINUS || is_digit) begin
          idle_mode      = jts_pkg::MODE_INT;
          idle_set_begin = 1'b1;
        end else begin
          idle_halt = 1'b1;
          idle_emit = 1'b1;
          idle_item = mk(jts_pkg::KIND_ERROR, pos, '0, jts_pkg::ERR_UNEXPECTED);
        end
      end
    endcase
  end

  always_comb begin
    mode_next      = mode;
    lit_kind_next  = lit_kind;
    lit_prog_next  = lit_prog;
    tok_begin_next = tok_begin;
    halted_next    = halted;
    pos_next       = pos_inc;
    items          = '0;
    n              = 2'd0;
    do_idle        = 1'b0;

    if (!halted) begin
      case (mode)
        jts_pkg::MODE_LITERAL: begin
          if ({1'b0, lit_prog} < cur_len &&
              text_byte == jts_pkg::lit_char(lit_kind, lit_prog)) begin
            lit_prog_next = prog_inc[1:0];
            if (prog_inc >= cur_len) begin
              items[n] = mk(jts_pkg::KIND_NULL + {2'b00, lit_kind}, tok_begin,
                            jts_pkg::PosBits'(cur_len) + jts_pkg::PosBits'(1),
                            jts_pkg::ERR_NONE);
              n = n + 2'd1;
              mode_next     = jts_pkg::MODE_IDLE;
              lit_prog_next = 2'd0;
            end
          end else begin
            items[n] = mk(jts_pkg::KIND_ERROR, tok_begin, '0, jts_pkg::ERR_LITERAL);
            n = n + 2'd1;
            halted_next = 1'b1;
          end
        end
        jts_pkg::MODE_STRING: begin
          if (text_byte == jts_pkg::CH_QUOTE) begin
            items[n] = mk(jts_pkg::KIND_STRING, tok_begin, pos - tok_begin, jts_pkg::ERR_NONE);
            n = n + 2'd1;
            mode_next = jts_pkg::MODE_IDLE;
          end
        end
        jts_pkg::MODE_INT, jts_pkg::MODE_FRAC: begin
          if (is_digit) begin
          end else if (text_byte == jts_pkg::CH_DOT && mode == jts_pkg::MODE_INT) begin
            mode_next = jts_pkg::MODE_DOT;
          end else begin
            // The byte that ends a number is scanned again as a fresh token.
            items[n] = mk(jts_pkg::KIND_NUMBER, tok_begin, pos - tok_begin, jts_pkg::ERR_NONE);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        jts_pkg::MODE_DOT: begin
          if (is_digit) begin
            mode_next = jts_pkg::MODE_FRAC;
          end else begin
            // No digit after the dot: the number stops before it, the dot is an error.
            items[n] = mk(jts_pkg::KIND_NUMBER, tok_begin,
                          pos - jts_pkg::PosBits'(1) - tok_begin, jts_pkg::ERR_NONE);
            n = n + 2'd1;
            items[n] = mk(jts_pkg::KIND_ERROR, pos - jts_pkg::PosBits'(1), '0,
                          jts_pkg::ERR_UNEXPECTED);
            n = n + 2'd1;
            halted_next = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        mode_next = idle_mode;
        if (idle_set_begin) begin
          tok_begin_next = idle_begin;
        end
        if (idle_mode == jts_pkg::MODE_LITERAL) begin
          lit_kind_next = idle_kind;
          lit_prog_next = 2'd0;
        end
        if (idle_halt) begin
          halted_next = 1'b1;
        end
        if (idle_emit) begin
          items[n] = idle_item;
          n = n + 2'd1;
        end
      end
    end

    if (final_byte) begin
      if (!halted_next) begin
        case (mode_next)
          jts_pkg::MODE_INT, jts_pkg::MODE_FRAC: begin
            items[n] = mk(jts_pkg::KIND_NUMBER, tok_begin_next, pos_inc - tok_begin_next,
                          jts_pkg::ERR_NONE);
            n = n + 2'd1;
          end
          jts_pkg::MODE_DOT: begin
            items[n] = mk(jts_pkg::KIND_NUMBER, tok_begin_next, pos - tok_begin_next,
                          jts_pkg::ERR_NONE);
            n = n + 2'd1;
            items[n] = mk(jts_pkg::KIND_ERROR, pos, '0, jts_pkg::ERR_UNEXPECTED);
            n = n + 2'd1;
          end
          jts_pkg::MODE_STRING: begin
            items[n] = mk(jts_pkg::KIND_ERROR, tok_begin_next - jts_pkg::PosBits'(1), '0,
                          jts_pkg::ERR_STRING);
            n = n + 2'd1;
          end
          jts_pkg::MODE_LITERAL: begin
            items[n] = mk(jts_pkg::KIND_ERROR, tok_begin_next, '0, jts_pkg::ERR_LITERAL);
            n = n + 2'd1;
          end
          default: begin
          end
        endcase
      end
      items[n] = mk(jts_pkg::KIND_END, pos_inc, '0, jts_pkg::ERR_NONE);
      n = n + 2'd1;
      mode_next      = jts_pkg::MODE_IDLE;
      lit_kind_next  = 2'd0;
      lit_prog_next  = 2'd0;
      pos_next       = '0;
      tok_begin_next = '0;
      halted_next    = 1'b0;
    end

    for (int i = 0; i < jts_pkg::MaxResults; i++) begin
      if (n != 2'd0 && 2'(i) == n - 2'd1) begin
        items[i].last = 1'b1;
      end
    end

    scan_out.count = n;
    scan_out.items = items;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= jts_pkg::MODE_IDLE;
      lit_kind  <= 2'd0;
      lit_prog  <= 2'd0;
      pos       <= '0;
      tok_begin <= '0;
      halted    <= 1'b0;
    end else if (step) begin
      mode      <= mode_next;
      lit_kind  <= lit_kind_next;
      lit_prog  <= lit_prog_next;
      pos       <= pos_next;
      tok_begin <= tok_begin_next;
      halted    <= halted_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/jts_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON token scanner: result queue
// Small register queue that takes up to three results per cycle and hands
// out one per output transaction.
// ----------------------------------------------------------------------------
module jts_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire jts_pkg::scan_out_t  push_data,
  output logic                     room,
  output logic                     head_valid,
  input  wire logic                pop,
  output jts_pkg::result_t         head
);

  jts_pkg::result_t entries [jts_pkg::QueueDepth];
  logic [jts_pkg::QueuePtrBits-1:0] wr_ptr, rd_ptr;
  logic [jts_pkg::QueuePtrBits:0]   count, count_next;
  logic [1:0]                       push_n;

  assign push_n     = push ? push_data.count : 2'd0;
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  // Enough free entries for the worst case of one byte.
  assign room       = (count <= (jts_pkg::QueuePtrBits+1)'(jts_pkg::QueueDepth
                                                          - jts_pkg::MaxResults));
  assign count_next = count + (jts_pkg::QueuePtrBits+1)'(push_n)
                    - (jts_pkg::QueuePtrBits+1)'(pop && head_valid);

  always_ff @(posedge clk) begin
    for (int i = 0; i < jts_pkg::MaxResults; i++) begin
      if (2'(i) < push_n) begin
        entries[wr_ptr + jts_pkg::QueuePtrBits'(i)] <= push_data.items[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + jts_pkg::QueuePtrBits'(push_n);
      if (pop && head_valid) begin
        rd_ptr <= rd_ptr + jts_pkg::QueuePtrBits'(1);
      end
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/jts_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON token scanner checker
// Port-level properties of the token stream, bound to the top level.
// ----------------------------------------------------------------------------
module jts_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        token_valid,
  input wire logic        token_ready,
  input wire logic [3:0]  token_kind,
  input wire logic [31:0] token_start,
  input wire logic [31:0] token_length,
  input wire logic [1:0]  error_code,
  input wire logic        last_of_run
);

  // A stalled token stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_ready |=> token_valid)
    else $error("token transaction withdrawn while stalled");

  // A stalled token keeps its kind, start, length and last flag.
  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_ready |=> $stable(token_kind) && $stable(token_start)
                                    && $stable(token_length) && $stable(last_of_run))
    else $error("token payload changed while stalled");

  // Errors carry a code and no length.
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_kind == jts_pkg::KIND_ERROR |->
      error_code != jts_pkg::ERR_NONE && token_length == 32'd0)
    else $error("error token malformed");

  // Only error tokens carry an error code.
  a_no_code: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_kind != jts_pkg::KIND_ERROR |-> error_code == jts_pkg::ERR_NONE)
    else $error("error code on a non-error token");

  // End of input always closes the run of its byte.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_kind == jts_pkg::KIND_END |-> last_of_run && token_length == 32'd0)
    else $error("end token not last of its run");

endmodule

bind json_token_scanner jts_checker u_jts_checker (
  .clk          (clk),
  .rst          (rst),
  .token_valid  (token_valid),
  .token_ready  (token_ready),
  .token_kind   (token_kind),
  .token_start  (token_start),
  .token_length (token_length),
  .error_code   (error_code),
  .last_of_run  (last_of_run)
);
`default_nettype wire

/* tb/tb_token_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token scoreboard
// Works out the tokens that each accepted byte of JSON text should produce
// and checks every token transaction, field by field, against the oldest
// token still waiting.
// ----------------------------------------------------------------------------
package tb_token_pkg;

  class token_scoreboard;
    jts_pkg::result_t expected_tokens[$];
    jts_pkg::result_t byte_tokens[$];
    int               fails;
    jts_pkg::mode_t   mode;
    logic [1:0]       lit_kind;
    int               lit_done;
    jts_pkg::pos_t    position;
    jts_pkg::pos_t    tok_begin;
    bit               halted;

    function new();
      fails = 0;
      clear_lexer();
    endfunction

    function void clear_lexer();
      mode      = jts_pkg::MODE_IDLE;
      lit_kind  = jts_pkg::LIT_NULL;
      lit_done  = 0;
      position  = '0;
      tok_begin = '0;
      halted    = 1'b0;
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    function void add_token(logic [3:0] kind, jts_pkg::pos_t start, jts_pkg::pos_t length,
                            logic [1:0] err);
      jts_pkg::result_t r;
      r.kind   = kind;
      r.start  = 32'(start);
      r.length = 32'(length);
      r.err    = err;
      r.last   = 1'b0;
      byte_tokens.push_back(r);
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= jts_pkg::CH_ZERO && b <= jts_pkg::CH_NINE;
    endfunction

    // Letters still to come once the first letter of a literal is seen.
    function string lit_tail(logic [1:0] k);
      if (k == jts_pkg::LIT_TRUE) return "rue";
      if (k == jts_pkg::LIT_FALSE) return "alse";
      return "ull";
    endfunction

    // Handles a byte that arrives between tokens.
    function void scan_between(logic [7:0] b, jts_pkg::pos_t p);
      case (b)
        jts_pkg::CH_SPACE, jts_pkg::CH_TAB, jts_pkg::CH_CR, jts_pkg::CH_LF: ;
        jts_pkg::CH_LBRACE: add_token(jts_pkg::KIND_LBRACE, p, 1, jts_pkg::ERR_NONE);
        jts_pkg::CH_RBRACE: add_token(jts_pkg::KIND_RBRACE, p, 1, jts_pkg::ERR_NONE);
        jts_pkg::CH_LBRACK: add_token(jts_pkg::KIND_LBRACKET, p, 1, jts_pkg::ERR_NONE);
        jts_pkg::CH_RBRACK: add_token(jts_pkg::KIND_RBRACKET, p, 1, jts_pkg::ERR_NONE);
        jts_pkg::CH_COMMA:  add_token(jts_pkg::KIND_COMMA, p, 1, jts_pkg::ERR_NONE);
        jts_pkg::CH_COLON:  add_token(jts_pkg::KIND_COLON, p, 1, jts_pkg::ERR_NONE);
        jts_pkg::CH_LOW_N, jts_pkg::CH_LOW_T, jts_pkg::CH_LOW_F: begin
          mode      = jts_pkg::MODE_LITERAL;
          lit_kind  = (b == jts_pkg::CH_LOW_N) ? jts_pkg::LIT_NULL :
                      (b == jts_pkg::CH_LOW_T) ? jts_pkg::LIT_TRUE : jts_pkg::LIT_FALSE;
          lit_done  = 0;
          tok_begin = p;
        end
        jts_pkg::CH_QUOTE: begin
          mode      = jts_pkg::MODE_STRING;
          tok_begin = p + 1;
        end
        default: begin
          if (b == jts_pkg::CH_MINUS || is_digit(b)) begin
            mode      = jts_pkg::MODE_INT;
            tok_begin = p;
          end else begin
            halted = 1'b1;
            add_token(jts_pkg::KIND_ERROR, p, 0, jts_pkg::ERR_UNEXPECTED);
          end
        end
      endcase
    endfunction

    // Scans one accepted byte and queues the tokens it should produce.
    function void note_byte(logic [7:0] b, logic fin);
      jts_pkg::pos_t    p;
      jts_pkg::pos_t    prev;
      string            tail;
      jts_pkg::result_t r;
      p    = position;
      prev = p - 1;
      byte_tokens.delete();
      if (!halted) begin
        case (mode)
          jts_pkg::MODE_LITERAL: begin
            tail = lit_tail(lit_kind);
            if (lit_done < tail.len() && b == 8'(tail[lit_done])) begin
              lit_done++;
              if (lit_done == tail.len()) begin
                add_token(jts_pkg::KIND_NULL + 4'(lit_kind), tok_begin,
                          jts_pkg::pos_t'(tail.len() + 1), jts_pkg::ERR_NONE);
                mode     = jts_pkg::MODE_IDLE;
                lit_done = 0;
              end
            end else begin
              add_token(jts_pkg::KIND_ERROR, tok_begin, 0, jts_pkg::ERR_LITERAL);
              halted = 1'b1;
            end
          end
          jts_pkg::MODE_STRING: begin
            if (b == jts_pkg::CH_QUOTE) begin
              add_token(jts_pkg::KIND_STRING, tok_begin, p - tok_begin, jts_pkg::ERR_NONE);
              mode = jts_pkg::MODE_IDLE;
            end
          end
          jts_pkg::MODE_INT, jts_pkg::MODE_FRAC: begin
            if (b == jts_pkg::CH_DOT && mode == jts_pkg::MODE_INT) begin
              mode = jts_pkg::MODE_DOT;
            end else if (!is_digit(b)) begin
              // The byte that ends a number is scanned as a fresh byte.
              add_token(jts_pkg::KIND_NUMBER, tok_begin, p - tok_begin, jts_pkg::ERR_NONE);
              mode = jts_pkg::MODE_IDLE;
              scan_between(b, p);
            end
          end
          jts_pkg::MODE_DOT: begin
            if (is_digit(b)) begin
              mode = jts_pkg::MODE_FRAC;
            end else begin
              // No digit after the dot: the number stops short of it.
              add_token(jts_pkg::KIND_NUMBER, tok_begin, prev - tok_begin, jts_pkg::ERR_NONE);
              add_token(jts_pkg::KIND_ERROR, prev, 0, jts_pkg::ERR_UNEXPECTED);
              halted = 1'b1;
            end
          end
          default: begin
            mode = jts_pkg::MODE_IDLE;
            scan_between(b, p);
          end
        endcase
      end
      p        = p + 1;
      position = p;
      if (fin) begin
        if (!halted) begin
          case (mode)
            jts_pkg::MODE_INT, jts_pkg::MODE_FRAC:
              add_token(jts_pkg::KIND_NUMBER, tok_begin, p - tok_begin, jts_pkg::ERR_NONE);
            jts_pkg::MODE_DOT: begin
              add_token(jts_pkg::KIND_NUMBER, tok_begin, p - 1 - tok_begin, jts_pkg::ERR_NONE);
              add_token(jts_pkg::KIND_ERROR, p - 1, 0, jts_pkg::ERR_UNEXPECTED);
            end
            jts_pkg::MODE_STRING:
              add_token(jts_pkg::KIND_ERROR, tok_begin - 1, 0, jts_pkg::ERR_STRING);
            jts_pkg::MODE_LITERAL:
              add_token(jts_pkg::KIND_ERROR, tok_begin, 0, jts_pkg::ERR_LITERAL);
            default: ;
          endcase
        end
        add_token(jts_pkg::KIND_END, p, 0, jts_pkg::ERR_NONE);
        clear_lexer();
      end
      if (byte_tokens.size() > 0) begin
        r      = byte_tokens.pop_back();
        r.last = 1'b1;
        byte_tokens.push_back(r);
      end
      foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_token(jts_pkg::result_t got);
      jts_pkg::result_t want;
      if (expected_tokens.size() == 0) begin
        $error("token with nothing predicted: kind %0d, start %0d", got.kind, got.start);
        fails++;
      end else begin
        want = expected_tokens.pop_front();
        compare_field("token_kind", want.kind, got.kind);
        compare_field("token_start", want.start, got.start);
        compare_field("token_length", want.length, got.length);
        compare_field("error_code", want.err, got.err);
        compare_field("last_of_run", want.last, got.last);
      end
    endfunction
  endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON token scanner testbench
// Feeds short hand-written texts for the corner cases, then random documents,
// mostly well formed with random content and some broken or pure noise. Byte
// transactions come in bursts with gaps, the token side stalls on its own
// pattern, and every token is checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int IdleLimit   = 2000;
  localparam int RandomBytes = 75;
  localparam int DrainCycles = 16;

  localparam logic [7:0] Blanks [4] = '{jts_pkg::CH_SPACE, jts_pkg::CH_TAB, jts_pkg::CH_CR,
                                        jts_pkg::CH_LF};
  localparam logic [7:0] Punct [6]  = '{jts_pkg::CH_LBRACE, jts_pkg::CH_RBRACE,
                                        jts_pkg::CH_LBRACK, jts_pkg::CH_RBRACK,
                                        jts_pkg::CH_COMMA, jts_pkg::CH_COLON};

  typedef enum int {STALL_NONE, STALL_COIN, STALL_BURST} stall_style_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        byte_valid  = 1'b0;
  logic [7:0]  text_byte   = 8'h00;
  logic        final_byte  = 1'b0;
  logic        token_ready = 1'b0;
  logic        byte_ready;
  logic        token_valid;
  logic [3:0]  token_kind;
  logic [31:0] token_start;
  logic [31:0] token_length;
  logic [1:0]  error_code;
  logic        last_of_run;

  tb_token_pkg::token_scoreboard sb;
  logic [7:0]      doc[$];
  int              burst_left   = 0;
  int              idle_cycles  = 0;
  int              stall_left   = 0;
  int              style_cycles = 0;
  stall_style_t    stall_style  = STALL_NONE;

  json_token_scanner dut (
    .clk,
    .rst,
    .byte_valid,
    .byte_ready,
    .text_byte,
    .final_byte,
    .token_valid,
    .token_ready,
    .token_kind,
    .token_start,
    .token_length,
    .error_code,
    .last_of_run
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((byte_valid && byte_ready) || (token_valid && token_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk);
    $display("tb_top: FAIL");
    $finish;
  end

  // Token side: check each transaction, then pick the next ready value.
  always @(posedge clk) begin
    jts_pkg::result_t got;
    if (!rst && token_valid && token_ready) begin
      got.kind   = token_kind;
      got.start  = token_start;
      got.length = token_length;
      got.err    = error_code;
      got.last   = last_of_run;
      sb.check_token(got);
    end
    if (style_cycles == 0) begin
      stall_style  = stall_style_t'($urandom_range(0, 2));
      style_cycles = $urandom_range(20, 80);
    end
    style_cycles--;
    if (stall_left > 0) begin
      stall_left--;
      token_ready <= 1'b0;
    end else if (stall_style == STALL_NONE) begin
      token_ready <= 1'b1;
    end else if (stall_style == STALL_COIN) begin
      token_ready <= 1'($urandom_range(0, 1));
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(2, 12);
      token_ready <= 1'b0;
    end else begin
      token_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_valid <= 1'b1;
    text_byte  <= b;
    final_byte <= fin;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    sb.note_byte(b, fin);
  endtask

  task automatic send_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) send_byte(8'(s[i]), fin && (i == s.len() - 1));
  endtask

  // Holds the byte side back until every predicted token has come out.
  task automatic drain();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic void add_blank();
    repeat ($urandom_range(0, 2)) doc.push_back(Blanks[$urandom_range(0, 3)]);
  endfunction

  function automatic void add_piece();
    string      word;
    logic [7:0] ch;
    case ($urandom_range(0, 4))
      1: begin
        case ($urandom_range(0, 2))
          0:       word = "null";
          1:       word = "true";
          default: word = "false";
        endcase
        for (int i = 0; i < word.len(); i++) doc.push_back(8'(word[i]));
      end
      2: begin
        doc.push_back(jts_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
          ch = 8'($urandom_range(0, 255));
          if (ch != jts_pkg::CH_QUOTE) doc.push_back(ch);
        end
        doc.push_back(jts_pkg::CH_QUOTE);
      end
      3: begin
        if ($urandom_range(0, 1) == 1) doc.push_back(jts_pkg::CH_MINUS);
        repeat ($urandom_range(1, 3))
          doc.push_back(jts_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0) begin
          doc.push_back(jts_pkg::CH_DOT);
          repeat ($urandom_range(1, 2))
            doc.push_back(jts_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
      end
      default: doc.push_back(Punct[$urandom_range(0, 5)]);
    endcase
  endfunction

  // Most documents are well formed; some get cut short or have one byte
  // overwritten, and a few are plain noise.
  function automatic void build_document();
    int shape;
    int pick;
    doc.delete();
    shape = $urandom_range(0, 9);
    if (shape == 9) begin
      repeat ($urandom_range(1, 6)) doc.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        add_blank();
        add_piece();
      end
      add_blank();
      if (shape >= 7) begin
        pick = $urandom_range(0, doc.size() - 1);
        if ($urandom_range(0, 1) == 1) begin
          doc = doc[0:pick];
        end else begin
          doc[pick] = 8'($urandom_range(0, 255));
        end
      end
    end
  endfunction

  initial begin
    int random_sent;
    random_sent = 0;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Structure, a string holding an all-ones byte, a fraction, and a lone
    // minus closed by a bracket.
    send_text("{\"", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("\":[1.5,-]}", 1'b0);
    // A dot followed by an all-zeros byte on the final position.
    send_text("\tnull 7.", 1'b0);
    send_byte(8'h00, 1'b1);
    // Unterminated string, literal mismatch, literal cut off by the end.
    send_text("\"a", 1'b1);
    send_text("fx", 1'b1);
    send_text("t", 1'b1);
    // Number closed by a newline, then an unexpected byte and an ignored one.
    send_byte(jts_pkg::CH_CR, 1'b0);
    send_text("5\n@x", 1'b1);
    drain();

    while (random_sent < RandomBytes) begin
      build_document();
      if ($urandom_range(0, 5) == 0) drain();
      foreach (doc[i]) send_byte(doc[i], i == doc.size() - 1);
      random_sent += doc.size();
    end
    byte_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.fails == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/jts_pkg.sv
rtl/core/jts_scan.sv
rtl/core/jts_queue.sv
rtl/core/json_token_scanner.sv
rtl/core/jts_checker.sv
tb/tb_token_pkg.sv
tb/tb_top.sv
